// ----- rtl/assert_macros.svh -----
// Assertion macros for the frame compositor RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IFC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("compositor assertion failed");
`define IFC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("compositor forbidden condition seen");
`else
`define IFC_ASSERT(lbl, clk, rst_n, prop)
`define IFC_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- rtl/ifc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame compositor package
// Request codes, disposal modes, sequencer states and shared types.
// ----------------------------------------------------------------------------
package ifc_pkg;

    typedef enum logic [1:0] {
        REQ_PAL_WRITE   = 2'd0,
        REQ_FRAME_BEGIN = 2'd1,
        REQ_PIXEL       = 2'd2,
        REQ_CANVAS_READ = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_CLR_ALL,
        ST_IDLE,
        ST_CLR_RECT,
        ST_PIXEL,
        ST_READ
    } state_t;

    localparam logic [2:0] DISP_KEEP       = 3'd1;
    localparam logic [2:0] DISP_CLEAR_RECT = 3'd2;

    localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;

    localparam logic [7:0] ALPHA_DRAWN = 8'hFF;
    localparam int         RGB_W       = 24;
    localparam int         CELL_W      = RGB_W + 1;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] width;
        logic [15:0] height;
    } rect_t;

    // memory port control between sequencer and storage
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctrl_t;

endpackage

// ----- rtl/ifc_canvas_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canvas store
// Single-port synchronous RAM, one drawn bit plus RGB per pixel.
// ----------------------------------------------------------------------------
module ifc_canvas_ram #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic                         clk,
    input  ifc_pkg::mem_ctrl_t           ctrl,
    input  logic [AW-1:0]                addr,
    input  logic [ifc_pkg::CELL_W-1:0]   wdata,
    output logic [ifc_pkg::CELL_W-1:0]   rdata
);

    logic [ifc_pkg::CELL_W-1:0] mem [DEPTH];
    logic [ifc_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ifc_palette_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette store
// Synchronous RAM of RGB entries, separate write and read addresses.
// ----------------------------------------------------------------------------
module ifc_palette_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                        clk,
    input  ifc_pkg::mem_ctrl_t          ctrl,
    input  logic [AW-1:0]               waddr,
    input  logic [ifc_pkg::RGB_W-1:0]   wdata,
    input  logic [AW-1:0]               raddr,
    output logic [ifc_pkg::RGB_W-1:0]   rdata
);

    logic [ifc_pkg::RGB_W-1:0] mem [DEPTH];
    logic [ifc_pkg::RGB_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/indexed_frame_compositor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed frame compositor
// Composites palette-indexed frames onto an RGBA canvas held in RAM.
// ----------------------------------------------------------------------------
// After reset the canvas RAM is swept to zero, one pixel a cycle, with no
// request taken meanwhile. A palette write is done when it is accepted. A
// drawn pixel reads the palette RAM when accepted, then writes the canvas;
// a pixel that is clipped, transparent or beyond the frame writes nothing.
// Canvas reads read the canvas RAM, then load the output register once the
// previous result has left it. A frame begin applies the disposal stored by
// the previous frame begin: keep adds nothing, a rectangle clear writes each
// clipped pixel of the previous frame, and any other code clears the whole
// canvas; all canvas traffic goes through the single canvas RAM port.
// Results sit in an output register, so
// requests other than a canvas read keep flowing while a result waits.
module indexed_frame_compositor #(
    parameter int MAX_WIDTH     = 128,
    parameter int MAX_HEIGHT    = 128,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // palette_select[0], color_index[8:1], color_rgb[32:9], rect_left[48:33],
    // rect_top[64:49], rect_width[80:65], rect_height[96:81],
    // transparent_enable[97], disposal[100:98], zero fill[103:101]
    input  logic [103:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16], pixel_alpha[31:24]
    output logic [31:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data
);

    localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int PAW       = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    // input fields
    logic        in_pal_sel;
    logic [7:0]  in_index;
    logic [23:0] in_rgb;
    logic [15:0] in_left, in_top, in_width, in_height;
    logic        in_tr_en;
    logic [2:0]  in_disposal;
    ifc_pkg::req_type_t in_req;

    assign in_pal_sel  = s_axis_tdata[0];
    assign in_index    = s_axis_tdata[8:1];
    assign in_rgb      = s_axis_tdata[32:9];
    assign in_left     = s_axis_tdata[48:33];
    assign in_top      = s_axis_tdata[64:49];
    assign in_width    = s_axis_tdata[80:65];
    assign in_height   = s_axis_tdata[96:81];
    assign in_tr_en    = s_axis_tdata[97];
    assign in_disposal = s_axis_tdata[100:98];
    assign in_req      = ifc_pkg::req_type_t'(s_axis_tuser);

    // configuration
    logic [7:0] cfg_width_reg, cfg_height_reg;
    logic [7:0] eff_w, eff_h;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= 8'd128;
            cfg_height_reg <= 8'd128;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ifc_pkg::REG_CANVAS_WIDTH)
            begin
                cfg_width_reg <= cfg_data;
            end
            else if (cfg_index == ifc_pkg::REG_CANVAS_HEIGHT)
            begin
                cfg_height_reg <= cfg_data;
            end
        end
    end

    assign eff_w = (32'(cfg_width_reg) > MAX_WIDTH) ? 8'(MAX_WIDTH) : cfg_width_reg;
    assign eff_h = (32'(cfg_height_reg) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : cfg_height_reg;

    // state
    ifc_pkg::state_t state_reg, state_next;
    ifc_pkg::rect_t  frame_reg, frame_next;
    logic [2:0]  pend_disp_reg, pend_disp_next;
    logic [15:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [8:0]  tkey_reg, tkey_next;
    logic        use_local_reg, use_local_next;
    logic [CW-1:0] sweep_reg, sweep_next;
    logic [15:0] cx_reg, cx_next, cy_reg, cy_next, x0_reg, x0_next;
    logic [16:0] x1_reg, x1_next, y1_reg, y1_next;
    logic [7:0]  px_reg, px_next, py_reg, py_next;
    logic        pal_zero_reg, pal_zero_next;
    logic        rd_in_reg, rd_in_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;

    // canvas and palette RAM ports
    ifc_pkg::mem_ctrl_t         cv_ctrl, gp_ctrl, lp_ctrl;
    logic [AW-1:0]              cv_addr;
    logic [ifc_pkg::CELL_W-1:0] cv_wdata, cv_rdata;
    logic [23:0]                gp_rdata, lp_rdata, pal_rgb;

    // helpers
    logic        acc;
    logic [16:0] dx, dy, rx1, ry1;
    logic [16:0] clr_x1, clr_y1;
    logic        pix_active, pix_draw;
    logic [7:0]  row_sel, col_sel;
    logic [16:0] addr_sum;

    assign acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ifc_pkg::ST_IDLE);

    assign dx  = 17'(frame_reg.left) + 17'(cur_x_reg);
    assign dy  = 17'(frame_reg.top) + 17'(cur_y_reg);
    assign rx1 = 17'(frame_reg.left) + 17'(frame_reg.width);
    assign ry1 = 17'(frame_reg.top) + 17'(frame_reg.height);
    assign clr_x1 = (rx1 > 17'(eff_w)) ? 17'(eff_w) : rx1;
    assign clr_y1 = (ry1 > 17'(eff_h)) ? 17'(eff_h) : ry1;

    assign pix_active = (frame_reg.width != 16'd0) && (cur_y_reg < frame_reg.height);
    assign pix_draw   = pix_active && (dx < 17'(eff_w)) && (dy < 17'(eff_h))
                        && !(tkey_reg[8] && (tkey_reg[7:0] == in_index));

    assign pal_rgb = use_local_reg ? lp_rdata : gp_rdata;

    // row * width + column for whichever stage owns the port
    always_comb
    begin
        case (state_reg)
            ifc_pkg::ST_CLR_RECT:
            begin
                row_sel = cy_reg[7:0];
                col_sel = cx_reg[7:0];
            end
            ifc_pkg::ST_PIXEL:
            begin
                row_sel = py_reg;
                col_sel = px_reg;
            end
            default:
            begin
                row_sel = in_top[7:0];
                col_sel = in_left[7:0];
            end
        endcase
    end

    assign addr_sum = 17'(16'(row_sel) * 16'(eff_w)) + 17'(col_sel);

    always_comb
    begin
        state_next     = state_reg;
        frame_next     = frame_reg;
        pend_disp_next = pend_disp_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        tkey_next      = tkey_reg;
        use_local_next = use_local_reg;
        sweep_next     = sweep_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pal_zero_next  = pal_zero_reg;
        rd_in_next     = rd_in_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        cv_ctrl        = '0;
        gp_ctrl        = '0;
        lp_ctrl        = '0;
        cv_addr        = AW'(addr_sum);
        cv_wdata       = '0;

        case (state_reg)
            ifc_pkg::ST_CLR_ALL:
            begin
                cv_ctrl.wr_en = 1'b1;
                cv_addr       = AW'(sweep_reg);
                sweep_next    = sweep_reg + CW'(1);
                if (sweep_reg == CW'(DEPTH - 1))
                begin
                    state_next = ifc_pkg::ST_IDLE;
                end
            end
            ifc_pkg::ST_CLR_RECT:
            begin
                cv_ctrl.wr_en = 1'b1;
                if (17'(cx_reg) + 17'd1 >= x1_reg)
                begin
                    cx_next = x0_reg;
                    cy_next = cy_reg + 16'd1;
                    if (17'(cy_reg) + 17'd1 >= y1_reg)
                    begin
                        state_next = ifc_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cx_next = cx_reg + 16'd1;
                end
            end
            ifc_pkg::ST_PIXEL:
            begin
                cv_ctrl.wr_en = 1'b1;
                cv_wdata      = {1'b1, pal_zero_reg ? 24'd0 : pal_rgb};
                state_next    = ifc_pkg::ST_IDLE;
            end
            ifc_pkg::ST_READ:
            begin
                // hold the RAM data until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    if (rd_in_reg)
                    begin
                        out_data_next = {cv_rdata[24] ? ifc_pkg::ALPHA_DRAWN : 8'd0,
                                         cv_rdata[7:0], cv_rdata[15:8], cv_rdata[23:16]};
                    end
                    else
                    begin
                        out_data_next = '0;
                    end
                    state_next = ifc_pkg::ST_IDLE;
                end
            end
            ifc_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    case (in_req)
                        ifc_pkg::REQ_PAL_WRITE:
                        begin
                            if (32'(in_index) < PALETTE_DEPTH)
                            begin
                                gp_ctrl.wr_en = !in_pal_sel;
                                lp_ctrl.wr_en = in_pal_sel;
                            end
                        end
                        ifc_pkg::REQ_FRAME_BEGIN:
                        begin
                            frame_next     = '{in_left, in_top, in_width, in_height};
                            pend_disp_next = in_disposal;
                            use_local_next = in_pal_sel;
                            tkey_next      = {in_tr_en, in_index};
                            cur_x_next     = '0;
                            cur_y_next     = '0;
                            if (pend_disp_reg == ifc_pkg::DISP_KEEP)
                            begin
                                state_next = ifc_pkg::ST_IDLE;
                            end
                            else if (pend_disp_reg == ifc_pkg::DISP_CLEAR_RECT)
                            begin
                                cx_next = frame_reg.left;
                                cy_next = frame_reg.top;
                                x0_next = frame_reg.left;
                                x1_next = clr_x1;
                                y1_next = clr_y1;
                                if (17'(frame_reg.left) < clr_x1
                                    && 17'(frame_reg.top) < clr_y1)
                                begin
                                    state_next = ifc_pkg::ST_CLR_RECT;
                                end
                            end
                            else
                            begin
                                sweep_next = '0;
                                state_next = ifc_pkg::ST_CLR_ALL;
                            end
                        end
                        ifc_pkg::REQ_PIXEL:
                        begin
                            if (pix_active)
                            begin
                                if (cur_x_reg + 16'd1 >= frame_reg.width)
                                begin
                                    cur_x_next = '0;
                                    cur_y_next = cur_y_reg + 16'd1;
                                end
                                else
                                begin
                                    cur_x_next = cur_x_reg + 16'd1;
                                end
                            end
                            if (pix_draw)
                            begin
                                gp_ctrl.rd_en = 1'b1;
                                lp_ctrl.rd_en = 1'b1;
                                pal_zero_next = !(32'(in_index) < PALETTE_DEPTH);
                                px_next       = dx[7:0];
                                py_next       = dy[7:0];
                                state_next    = ifc_pkg::ST_PIXEL;
                            end
                        end
                        ifc_pkg::REQ_CANVAS_READ:
                        begin
                            rd_in_next    = (in_left < 16'(eff_w)) && (in_top < 16'(eff_h));
                            cv_ctrl.rd_en = (in_left < 16'(eff_w)) && (in_top < 16'(eff_h));
                            state_next    = ifc_pkg::ST_READ;
                        end
                        default:
                        begin
                            state_next = ifc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ifc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ifc_pkg::ST_CLR_ALL;
            frame_reg     <= '0;
            pend_disp_reg <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            tkey_reg      <= '0;
            use_local_reg <= 1'b0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            frame_reg     <= frame_next;
            pend_disp_reg <= pend_disp_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            tkey_reg      <= tkey_next;
            use_local_reg <= use_local_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        x0_reg       <= x0_next;
        x1_reg       <= x1_next;
        y1_reg       <= y1_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        pal_zero_reg <= pal_zero_next;
        rd_in_reg    <= rd_in_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    ifc_canvas_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_canvas (
        .clk   (clk),
        .ctrl  (cv_ctrl),
        .addr  (cv_addr),
        .wdata (cv_wdata),
        .rdata (cv_rdata)
    );

    ifc_palette_ram #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (PAW)
    ) u_global_pal (
        .clk   (clk),
        .ctrl  (gp_ctrl),
        .waddr (PAW'(in_index)),
        .wdata (in_rgb),
        .raddr (PAW'(in_index)),
        .rdata (gp_rdata)
    );

    ifc_palette_ram #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (PAW)
    ) u_local_pal (
        .clk   (clk),
        .ctrl  (lp_ctrl),
        .waddr (PAW'(in_index)),
        .wdata (in_rgb),
        .raddr (PAW'(in_index)),
        .rdata (lp_rdata)
    );

`include "assert_macros.svh"

    `IFC_ASSERT_NEVER(a_no_accept_busy, clk, rst_n, s_axis_tready && (state_reg != ifc_pkg::ST_IDLE))
    `IFC_ASSERT_NEVER(a_port_conflict, clk, rst_n, cv_ctrl.wr_en && cv_ctrl.rd_en)
    `IFC_ASSERT(a_read_then_wait, clk, rst_n, (acc && (in_req == ifc_pkg::REQ_CANVAS_READ)) |=> (state_reg == ifc_pkg::ST_READ))
    `IFC_ASSERT(a_pixel_one_write, clk, rst_n, (state_reg == ifc_pkg::ST_PIXEL) |=> (state_reg == ifc_pkg::ST_IDLE))

endmodule
